// File: rtl/trp_pkg.sv
// Package for the touch report parser: widths, header codes, register
// indexes, parser phase encoding and the item passed from parser to scaler.
// No dependencies.
package trp_pkg;

	localparam int DATA_W     = 8;
	localparam int SPAN_W     = 11;
	localparam int HIGH_SHIFT = 7;
	localparam int RAW_W      = DATA_W + HIGH_SHIFT + 1;
	localparam int PROD_W     = RAW_W + SPAN_W;
	localparam int FOLD_BITS  = 12;
	localparam int FULL_SCALE = 2**FOLD_BITS - 1;
	localparam int QUOT_W     = PROD_W - FOLD_BITS + 1;

	localparam logic [DATA_W-1:0] HDR_PEN_DOWN = 8'h81;
	localparam logic [DATA_W-1:0] HDR_PEN_UP   = 8'h80;

	localparam logic [SPAN_W-1:0] WIDTH_RESET  = 11'd800;
	localparam logic [SPAN_W-1:0] HEIGHT_RESET = 11'd480;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_X_LO,
		PH_X_HI,
		PH_Y_LO,
		PH_Y_HI
	} phase_t;

	typedef struct packed {
		logic             pen;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} trp_item_t;

endpackage

// File: rtl/trp_byte_if.sv
// Byte channel from the touch controller link: valid/ready plus one byte.
// Depends on trp_pkg.
interface trp_byte_if;
	import trp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

// File: rtl/trp_report_if.sv
// Report channel: valid/ready plus pen state, scaled coordinates and range flag.
// Depends on trp_pkg.
interface trp_report_if;
	import trp_pkg::*;

	logic              valid;
	logic              ready;
	logic              pen_down;
	logic [SPAN_W-1:0] x_pixel;
	logic [SPAN_W-1:0] y_pixel;
	logic              out_of_range;

	modport source (output valid, output pen_down, output x_pixel, output y_pixel,
		output out_of_range, input ready);
	modport sink (input valid, input pen_down, input x_pixel, input y_pixel,
		input out_of_range, output ready);

endinterface

// File: rtl/trp_parser.sv
// Byte framing for touch reports: tracks header and data phase, collects
// the raw X and Y readings. Depends on trp_pkg.
module trp_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [trp_pkg::DATA_W-1:0]       rx_byte,
	output logic                             done,
	output trp_pkg::trp_item_t               item
);
	import trp_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic              is_hdr;
	logic              pen_q;
	logic [DATA_W-1:0] x_lo_q;
	logic [DATA_W-1:0] y_lo_q;
	logic [RAW_W-1:0]  raw_x_q;

	assign is_hdr = (rx_byte == HDR_PEN_DOWN) || (rx_byte == HDR_PEN_UP);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (is_hdr) begin
				phase_d = PH_X_LO;
			end else begin
				unique case (phase_q)
					PH_IDLE: phase_d = PH_IDLE;
					PH_X_LO: phase_d = PH_X_HI;
					PH_X_HI: phase_d = PH_Y_LO;
					PH_Y_LO: phase_d = PH_Y_HI;
					PH_Y_HI: phase_d = PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		done       = accept && !is_hdr && (phase_q == PH_Y_HI);
		item.pen   = pen_q;
		item.raw_x = raw_x_q;
		item.raw_y = (RAW_W'(rx_byte) << HIGH_SHIFT) + RAW_W'(y_lo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_hdr) begin
				pen_q <= (rx_byte == HDR_PEN_DOWN);
			end else begin
				case (phase_q)
					PH_X_LO: x_lo_q  <= rx_byte;
					PH_X_HI: raw_x_q <= (RAW_W'(rx_byte) << HIGH_SHIFT) + RAW_W'(x_lo_q);
					PH_Y_LO: y_lo_q  <= rx_byte;
					default: ;
				endcase
			end
		end
	end

	a_done_in_last_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> phase_q == PH_IDLE)
		else $error("report completed without returning to idle");

endmodule

// File: rtl/touch_report_parser.sv
// Touch report parser top level: config registers, parser, scaling pipeline.
// Depends on trp_pkg, trp_byte_if, trp_report_if, trp_parser.
//
//   port     | dir  | carries
//   ---------+------+------------------------------------------------
//   bytes    | in   | rx_byte, one byte per transaction
//   reports  | out  | pen_down, x_pixel, y_pixel, out_of_range
//   cfg_*    | in   | screen_width / screen_height writes
//
// One byte is taken per cycle while bytes.ready is high. After its last
// byte a report is registered through capture, multiply by the span, and
// divide by full scale with range check. Reset returns the parser to
// waiting for a header and loads 800 x 480. A stalled report output holds
// the pipeline; bytes keep flowing while any stage is empty.
module touch_report_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  trp_pkg::cfg_reg_t            cfg_index,
	input  logic [trp_pkg::SPAN_W-1:0]   cfg_data,
	trp_byte_if.sink                     bytes,
	trp_report_if.source                 reports
);
	import trp_pkg::*;

	logic [SPAN_W-1:0] width_q;
	logic [SPAN_W-1:0] height_q;

	logic              accept;
	logic              done;
	trp_item_t         item;

	logic              rdy_out;
	logic              rdy_s2;
	logic              rdy_s1;

	logic              v_s1;
	trp_item_t         item_s1;

	logic              v_s2;
	logic              pen_s2;
	logic [PROD_W-1:0] prod_x_s2;
	logic [PROD_W-1:0] prod_y_s2;

	logic [QUOT_W-1:0] quot_x;
	logic [QUOT_W-1:0] quot_y;
	logic              bad;

	logic              out_valid_q;
	logic              out_pen_q;
	logic [SPAN_W-1:0] out_x_q;
	logic [SPAN_W-1:0] out_y_q;
	logic              out_bad_q;

	function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
		logic [QUOT_W-1:0]    a;
		logic [QUOT_W-1:0]    s;
		logic [QUOT_W-1:0]    a2;
		logic [FOLD_BITS:0]   t;
		logic                 carry;
		a     = QUOT_W'(p >> FOLD_BITS);
		s     = a + QUOT_W'(p[FOLD_BITS-1:0]);
		a2    = s >> FOLD_BITS;
		t     = (FOLD_BITS+1)'(a2) + {1'b0, s[FOLD_BITS-1:0]};
		carry = (t >= (FOLD_BITS+1)'(FULL_SCALE));
		return a + a2 + QUOT_W'(carry);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign rdy_out     = !out_valid_q || reports.ready;
	assign rdy_s2      = !v_s2 || rdy_out;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign bytes.ready = rdy_s1;
	assign accept      = bytes.valid && rdy_s1;

	trp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (bytes.rx_byte),
		.done    (done),
		.item    (item)
	);

	always_comb begin
		quot_x = div_full_scale(prod_x_s2);
		quot_y = div_full_scale(prod_y_s2);
		bad    = (quot_x > QUOT_W'(width_q)) || (quot_y > QUOT_W'(height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= done;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			item_s1 <= item;
		end
		if (rdy_s2) begin
			pen_s2    <= item_s1.pen;
			prod_x_s2 <= PROD_W'(item_s1.raw_x) * PROD_W'(width_q);
			prod_y_s2 <= PROD_W'(item_s1.raw_y) * PROD_W'(height_q);
		end
		if (rdy_out) begin
			out_pen_q <= pen_s2;
			out_bad_q <= bad;
			out_x_q   <= bad ? '0 : quot_x[SPAN_W-1:0];
			out_y_q   <= bad ? '0 : quot_y[SPAN_W-1:0];
		end
	end

	assign reports.valid        = out_valid_q;
	assign reports.pen_down     = out_pen_q;
	assign reports.x_pixel      = out_x_q;
	assign reports.y_pixel      = out_y_q;
	assign reports.out_of_range = out_bad_q;

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s2))
		else $error("report appeared without a scaled item behind it");

	a_bad_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bad_q |-> out_x_q == '0 && out_y_q == '0)
		else $error("out-of-range report carries nonzero coordinates");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_bad_q |-> out_x_q <= width_q && out_y_q <= height_q)
		else $error("in-range report exceeds the screen span");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s2 |=> v_s2 && $stable(prod_x_s2) && $stable(prod_y_s2))
		else $error("stalled product stage lost its contents");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for touch_report_parser: directed byte table, then random report traffic.
// Checks reports against table rows or a parser/scaler model; depends on trp_pkg, ifs, DUT.
module testbench;
	import trp_pkg::*;

	localparam int unsigned COUNTS_FULL = 4095;

	typedef struct packed {
		logic              pen;
		logic [SPAN_W-1:0] x;
		logic [SPAN_W-1:0] y;
		logic              oor;
	} touch_report_t;

	typedef struct {
		logic [DATA_W-1:0] rx;
		bit                typed;
		bit                yields;
		touch_report_t     want;
	} byte_row_t;

	localparam touch_report_t NO_REPORT = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	cfg_reg_t          cfg_index;
	logic [SPAN_W-1:0] cfg_data;

	trp_byte_if   bytes_ch();
	trp_report_if reports_ch();

	touch_report_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (bytes_ch),
		.reports   (reports_ch)
	);

	always #4 clk = ~clk;

	logic [SPAN_W-1:0] span_x = WIDTH_RESET;
	logic [SPAN_W-1:0] span_y = HEIGHT_RESET;
	phase_t            parse_phase = PH_IDLE;
	logic              pen_state = 1'b0;
	logic [DATA_W-1:0] x_lo = '0;
	logic [DATA_W-1:0] x_hi = '0;
	logic [DATA_W-1:0] y_lo = '0;

	touch_report_t pending_reports[$];
	int            mismatches = 0;
	int            src_idle;
	int            snk_idle;

	byte_row_t dir_rows [24] = '{
		'{8'h00,        1'b1, 1'b0, NO_REPORT},
		'{HDR_PEN_DOWN, 1'b1, 1'b0, NO_REPORT},
		'{8'h00,        1'b1, 1'b0, NO_REPORT},
		'{8'h00,        1'b1, 1'b0, NO_REPORT},
		'{8'h00,        1'b1, 1'b0, NO_REPORT},
		'{8'h00,        1'b1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b0}},
		'{8'h42,        1'b1, 1'b0, NO_REPORT},
		'{HDR_PEN_UP,   1'b1, 1'b0, NO_REPORT},
		'{8'h7F,        1'b1, 1'b0, NO_REPORT},
		'{8'h1F,        1'b1, 1'b0, NO_REPORT},
		'{8'h7F,        1'b1, 1'b0, NO_REPORT},
		'{8'h1F,        1'b1, 1'b1, '{1'b0, 11'd800, 11'd480, 1'b0}},
		'{HDR_PEN_DOWN, 1'b1, 1'b0, NO_REPORT},
		'{8'hFF,        1'b1, 1'b0, NO_REPORT},
		'{8'hFF,        1'b1, 1'b0, NO_REPORT},
		'{8'hFF,        1'b1, 1'b0, NO_REPORT},
		'{8'hFF,        1'b1, 1'b1, '{1'b1, 11'd0, 11'd0, 1'b1}},
		'{HDR_PEN_DOWN, 1'b0, 1'b0, NO_REPORT},
		'{8'h10,        1'b0, 1'b0, NO_REPORT},
		'{HDR_PEN_UP,   1'b0, 1'b0, NO_REPORT},
		'{8'h01,        1'b0, 1'b0, NO_REPORT},
		'{8'h02,        1'b0, 1'b0, NO_REPORT},
		'{8'h03,        1'b0, 1'b0, NO_REPORT},
		'{8'h04,        1'b0, 1'b0, NO_REPORT}
	};

	function automatic longint unsigned scaled(input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi, input logic [SPAN_W-1:0] span);
		longint unsigned raw;
		raw = longint'(hi) * 128 + longint'(lo);
		return (raw * longint'(span)) / COUNTS_FULL;
	endfunction

	function automatic bit parse_byte(input logic [DATA_W-1:0] b, output touch_report_t rep);
		longint unsigned sx;
		longint unsigned sy;
		bit              bad;
		rep = NO_REPORT;
		if (b == HDR_PEN_DOWN || b == HDR_PEN_UP) begin
			pen_state = (b == HDR_PEN_DOWN);
			parse_phase = PH_X_LO;
			return 1'b0;
		end
		case (parse_phase)
			PH_X_LO: begin
				x_lo = b;
				parse_phase = PH_X_HI;
				return 1'b0;
			end
			PH_X_HI: begin
				x_hi = b;
				parse_phase = PH_Y_LO;
				return 1'b0;
			end
			PH_Y_LO: begin
				y_lo = b;
				parse_phase = PH_Y_HI;
				return 1'b0;
			end
			PH_Y_HI: begin
				parse_phase = PH_IDLE;
			end
			default: begin
				parse_phase = PH_IDLE;
				return 1'b0;
			end
		endcase
		sx = scaled(x_lo, x_hi, span_x);
		sy = scaled(y_lo, b, span_y);
		bad = (sx > longint'(span_x)) || (sy > longint'(span_y));
		rep.pen = pen_state;
		rep.x   = bad ? '0 : sx[SPAN_W-1:0];
		rep.y   = bad ? '0 : sy[SPAN_W-1:0];
		rep.oor = bad;
		return 1'b1;
	endfunction

	// hold valid across back-to-back transactions; drop it only while idling
	task automatic send_byte(input logic [DATA_W-1:0] b, input bit typed, input bit yields,
			input touch_report_t want);
		touch_report_t rep;
		bit            got;
		while ($urandom_range(99) < src_idle) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid   <= 1'b1;
		bytes_ch.rx_byte <= b;
		do @(posedge clk); while (!bytes_ch.ready);
		got = parse_byte(b, rep);
		if (typed) begin
			if (yields)
				pending_reports.push_back(want);
		end else if (got) begin
			pending_reports.push_back(rep);
		end
	endtask

	function automatic logic [DATA_W-1:0] data_byte(input bit high_part);
		logic [DATA_W-1:0] v;
		do begin
			if (high_part && $urandom_range(99) < 70)
				v = DATA_W'($urandom_range(31));
			else
				v = DATA_W'($urandom_range(255));
		end while (v == HDR_PEN_DOWN || v == HDR_PEN_UP);
		return v;
	endfunction

	task automatic run_traffic(input int n_bytes);
		int sent;
		int pick;
		int cut;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				send_byte($urandom_range(1) ? HDR_PEN_DOWN : HDR_PEN_UP, 1'b0, 1'b0, NO_REPORT);
				cut = (pick < 75) ? 4 : $urandom_range(3);
				for (int i = 0; i < cut; i++)
					send_byte(data_byte(i[0]), 1'b0, 1'b0, NO_REPORT);
				sent += 1 + cut;
			end else begin
				send_byte(DATA_W'($urandom_range(255)), 1'b0, 1'b0, NO_REPORT);
				sent += 1;
			end
		end
	endtask

	task automatic settle();
		bytes_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_spans(input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		span_x = w;
		span_y = h;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : report_check
		touch_report_t seen;
		touch_report_t want;
		if (arst_n && reports_ch.valid && reports_ch.ready) begin
			seen = {reports_ch.pen_down, reports_ch.x_pixel, reports_ch.y_pixel,
				reports_ch.out_of_range};
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: pen %0d x %0d y %0d oor %0d",
						seen.pen, seen.x, seen.y, seen.oor);
			end else begin
				want = pending_reports.pop_front();
				if (seen.pen !== want.pen || seen.x !== want.x || seen.y !== want.y
						|| seen.oor !== want.oor) begin
					mismatches++;
					if (mismatches <= 10)
						$display("report mismatch: expected pen %0d x %0d y %0d oor %0d, got pen %0d x %0d y %0d oor %0d",
							want.pen, want.x, want.y, want.oor,
							seen.pen, seen.x, seen.y, seen.oor);
				end
			end
		end
		reports_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle);
	end

	initial begin : main_seq
		logic [SPAN_W-1:0] w;
		logic [SPAN_W-1:0] h;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_SCREEN_WIDTH;
		cfg_data         = '0;
		bytes_ch.valid   = 1'b0;
		bytes_ch.rx_byte = '0;
		reports_ch.ready = 1'b0;
		src_idle         = 19;
		snk_idle         = 82;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].want);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin w = 11'd1;    h = 11'd1;    end
				1: begin w = 11'd2047; h = 11'd2047; end
				2: begin w = 11'd0;    h = 11'd2047; end
				3: begin
					w = SPAN_W'($urandom_range(1, 2047));
					h = SPAN_W'($urandom_range(1, 2047));
				end
				4: begin w = 11'd2047; h = 11'd1;    end
				default: begin
					w = SPAN_W'($urandom_range(1, 2047));
					h = SPAN_W'($urandom_range(1, 2047));
				end
			endcase
			set_spans(w, h);
			src_idle = (p < 2) ? 19 : (p < 4) ? 82 : 0;
			snk_idle = (p < 2) ? 82 : (p < 4) ? 19 : 0;
			run_traffic(225);
			settle();
		end

		mismatches += pending_reports.size();
		if (mismatches == 0)
			$display("touch_report_parser test passed");
		else
			$display("touch_report_parser test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("touch_report_parser test failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/trp_pkg.sv
rtl/trp_byte_if.sv
rtl/trp_report_if.sv
rtl/trp_parser.sv
rtl/touch_report_parser.sv
dv/testbench.sv
